### hdl/assert_macros.svh
// Assertion shorthands shared by the RTL files.
// Both check on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kbs_pkg.sv
`default_nettype none

package kbs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int TS_W  = 16;
    localparam int IWB_W = 24;
    localparam int ADDR_W = 3;

    // Register selects, taken from paddr[2].
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_INV_WB    = 1'b1;

    localparam logic [TS_W-1:0]  TIME_STEP_RST = 16'd3277;
    localparam logic [IWB_W-1:0] INV_WB_RST    = 24'd32768;

    localparam logic signed [15:0] STEER_LIMIT = 16'sd24576;
    localparam logic [31:0] STEER_TO_BA = 32'd2734261102;
    localparam logic [63:0] RAD_TO_BA   = 64'd44798133900177;
    localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;
    localparam logic signed [68:0] R_LIMIT = 69'sd17179869183;

    localparam logic [31:0] ATAN_BA [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [31:0] accel_in;
        logic signed [15:0] steer_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] heading_out;
        logic signed [31:0] speed_out;
        logic signed [47:0] pos_x_out;
        logic signed [47:0] pos_y_out;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MA, OP_SPD, OP_MD, OP_D, OP_ANG, OP_R,
        OP_DIV, OP_T, OP_MW, OP_W, OP_MLL, OP_HLL, OP_HHL, OP_HLH,
        OP_HC, OP_MX, OP_X, OP_Y, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_idle;
        logic div_idle;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/kbs_cordic.sv
`default_nettype none
`include "assert_macros.svh"

module kbs_cordic import kbs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [31:0]             i_angle,
    output logic                         o_idle,
    output logic signed [FRAC_BITS+2:0]  o_cos,
    output logic signed [FRAC_BITS+2:0]  o_sin
);

    localparam int CW    = FRAC_BITS + 3;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [63:0] X0_WIDE =
        (INV_GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic signed [CW-1:0] X0 = CW'(X0_WIDE);

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_flip;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [33:0]      r_z;

    logic                    flip;
    logic [31:0]             ang_fold;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [33:0]      atan_s;

    // Angles in the back half plane are turned by half a turn first.
    always_comb begin
        flip     = ((i_angle + 32'h4000_0000) & 32'h8000_0000) != 32'd0;
        ang_fold = flip ? (i_angle ^ 32'h8000_0000) : i_angle;
        dx       = r_y >>> r_cnt;
        dy       = r_x >>> r_cnt;
        atan_s   = $signed({2'b00, ATAN_BA[5'(r_cnt)]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= X0;
            r_y    <= '0;
            r_z    <= 34'($signed(ang_fold));
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_s;
            end
        end
    end

    assign o_idle = !r_busy;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

    `KBS_ASSERT_SAME(a_cordic_no_restart, r_busy, !i_start, "CORDIC restarted while busy")

endmodule

`default_nettype wire

### hdl/kbs_div.sv
`default_nettype none
`include "assert_macros.svh"

module kbs_div import kbs_pkg::*; #(
    parameter int NUM_W = 2 * FRAC_BITS_DEF + 3,
    parameter int DEN_W = FRAC_BITS_DEF + 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_idle,
    output logic [NUM_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = !diff[DEN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_idle = !r_busy;
    assign o_quo  = r_quo;

    `KBS_ASSERT_SAME(a_div_no_restart, r_busy, !i_start, "Divider restarted while busy")

endmodule

`default_nettype wire

### hdl/kbs_dp.sv
`default_nettype none

module kbs_dp import kbs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire t_in_item          i_in_data,
    input  wire logic [TS_W-1:0]   i_time_step,
    input  wire logic [IWB_W-1:0]  i_inv_wb,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data
);

    localparam int CW = FRAC_BITS + 3;
    localparam int NW = CW + FRAC_BITS;
    localparam int TW = FRAC_BITS + 6;
    localparam logic [NW-1:0] TMAX = NW'(1) << (FRAC_BITS + 4);
    localparam logic signed [68:0] HALF_F = 69'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0]   r_accel;
    logic signed [15:0]   r_steer;
    logic signed [31:0]   r_speed;
    logic [31:0]          r_heading;
    logic signed [47:0]   r_x;
    logic signed [47:0]   r_y;
    logic signed [31:0]   r_d;
    logic signed [34:0]   r_r;
    logic signed [TW-1:0] r_t;
    logic [63:0]          r_w;
    logic [31:0]          r_h;
    logic                 r_neg;
    logic signed [68:0]   r_prod;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic signed [35:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [68:0]   p_r16;
    logic signed [68:0]   p_rf;
    logic [68:0]          p_ll;
    logic signed [33:0]   spd_sum;
    logic signed [31:0]   spd_sat;
    logic signed [49:0]   pos_sum;
    logic signed [47:0]   pos_sat;
    logic signed [34:0]   r_clamped;
    logic signed [15:0]   steer_c;

    logic                 cor_start;
    logic [31:0]          cor_angle;
    logic                 cor_idle;
    logic signed [CW-1:0] cor_cos;
    logic signed [CW-1:0] cor_sin;

    logic                 div_start;
    logic [CW-1:0]        sin_abs;
    logic [CW-1:0]        den;
    logic [NW-1:0]        num;
    logic                 div_idle;
    logic [NW-1:0]        quo;
    logic [FRAC_BITS+4:0] quo_c;

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MA: begin
                mul_a = 36'(r_accel);
                mul_b = $signed({17'd0, i_time_step});
            end
            OP_MD: begin
                mul_a = 36'(r_speed);
                mul_b = $signed({17'd0, i_time_step});
            end
            OP_D: begin
                mul_a = 36'(r_steer);
                mul_b = $signed({1'b0, STEER_TO_BA});
            end
            OP_ANG: begin
                mul_a = 36'(r_d);
                mul_b = $signed({9'd0, i_inv_wb});
            end
            OP_MW: begin
                mul_a = 36'(r_r);
                mul_b = 33'(r_t);
            end
            OP_MLL: begin
                mul_a = $signed({4'd0, r_w[31:0]});
                mul_b = $signed({1'b0, RAD_TO_BA[31:0]});
            end
            OP_HLL: begin
                mul_a = $signed({4'd0, r_w[63:32]});
                mul_b = $signed({1'b0, RAD_TO_BA[31:0]});
            end
            OP_HHL: begin
                mul_a = $signed({4'd0, r_w[31:0]});
                mul_b = $signed({1'b0, RAD_TO_BA[63:32]});
            end
            OP_MX: begin
                mul_a = 36'(r_d);
                mul_b = 33'(cor_cos);
            end
            OP_X: begin
                mul_a = 36'(r_d);
                mul_b = 33'(cor_sin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        p_r16 = (r_prod + 69'sd32768) >>> 16;
        p_rf  = (r_prod + HALF_F) >>> FRAC_BITS;
        p_ll  = r_prod + 69'sd2147483648;

        spd_sum = 34'(r_speed) + 34'(p_r16);
        if (spd_sum > 34'sd2147483647) begin
            spd_sat = 32'sh7FFF_FFFF;
        end else if (spd_sum < -34'sd2147483648) begin
            spd_sat = 32'sh8000_0000;
        end else begin
            spd_sat = 32'(spd_sum);
        end

        pos_sum = (i_cmd.op == OP_X) ? 50'(r_x) + 50'(p_rf) : 50'(r_y) + 50'(p_rf);
        if (pos_sum > 50'sh0_7FFF_FFFF_FFFF) begin
            pos_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (pos_sum < -50'sh0_8000_0000_0000) begin
            pos_sat = 48'sh8000_0000_0000;
        end else begin
            pos_sat = 48'(pos_sum);
        end

        if (p_r16 > R_LIMIT) begin
            r_clamped = 35'(R_LIMIT);
        end else if (p_r16 < -R_LIMIT) begin
            r_clamped = 35'(-R_LIMIT);
        end else begin
            r_clamped = 35'(p_r16);
        end

        if (i_in_data.steer_angle > STEER_LIMIT) begin
            steer_c = STEER_LIMIT;
        end else if (i_in_data.steer_angle < -STEER_LIMIT) begin
            steer_c = -STEER_LIMIT;
        end else begin
            steer_c = i_in_data.steer_angle;
        end

        cor_start = (i_cmd.op == OP_ANG) || (i_cmd.op == OP_HC);
        cor_angle = (i_cmd.op == OP_ANG) ? p_r16[31:0] : r_heading;

        // tan = (sin << F) / cos on magnitudes; a cosine below one LSB counts as one.
        div_start = (i_cmd.op == OP_DIV);
        sin_abs   = cor_sin[CW-1] ? CW'(-cor_sin) : CW'(cor_sin);
        den       = (cor_cos < 1) ? CW'(1) : CW'(cor_cos);
        num       = {sin_abs, {FRAC_BITS{1'b0}}};
        quo_c     = (quo > TMAX) ? TMAX[FRAC_BITS+4:0] : quo[FRAC_BITS+4:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_heading   <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_SPD: r_speed   <= spd_sat;
                OP_HLH: r_heading <= r_heading + r_h + r_prod[31:0];
                OP_X:   r_x       <= pos_sat;
                OP_Y:   r_y       <= pos_sat;
                default: begin
                end
            endcase
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_accel <= i_in_data.accel_in;
                r_steer <= steer_c;
            end
            OP_D:   r_d   <= 32'(p_r16);
            OP_R:   r_r   <= r_clamped;
            OP_DIV: r_neg <= cor_sin[CW-1];
            OP_T:   r_t   <= r_neg ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
            OP_W:   r_w   <= 64'(p_rf);
            OP_HLL: r_h   <= p_ll[63:32];
            OP_HHL: r_h   <= r_h + r_prod[31:0];
            OP_OUT: begin
                r_out.heading_out <= $signed(r_heading);
                r_out.speed_out   <= r_speed;
                r_out.pos_x_out   <= r_x;
                r_out.pos_y_out   <= r_y;
            end
            default: begin
            end
        endcase
    end

    kbs_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_idle  (cor_idle),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    kbs_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_idle  (div_idle),
        .o_quo   (quo)
    );

    assign o_stat.cordic_idle = cor_idle;
    assign o_stat.div_idle    = div_idle;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

`default_nettype wire

### hdl/kbs_ctrl.sv
`default_nettype none

module kbs_ctrl import kbs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_dp_stat  i_stat,
    output t_dp_cmd        o_cmd
);

    typedef enum logic [22:0] {
        ST_IDLE = 23'h000001,
        ST_MA   = 23'h000002,
        ST_SPD  = 23'h000004,
        ST_MD   = 23'h000008,
        ST_D    = 23'h000010,
        ST_ANG  = 23'h000020,
        ST_R    = 23'h000040,
        ST_CW1  = 23'h000080,
        ST_DIV  = 23'h000100,
        ST_DW   = 23'h000200,
        ST_T    = 23'h000400,
        ST_MW   = 23'h000800,
        ST_W    = 23'h001000,
        ST_MLL  = 23'h002000,
        ST_HLL  = 23'h004000,
        ST_HHL  = 23'h008000,
        ST_HLH  = 23'h010000,
        ST_HC   = 23'h020000,
        ST_CW2  = 23'h040000,
        ST_MX   = 23'h080000,
        ST_X    = 23'h100000,
        ST_Y    = 23'h200000,
        ST_FIN  = 23'h400000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MA;
                end
            end
            ST_MA:  begin o_cmd.op = OP_MA;  n_state = ST_SPD; end
            ST_SPD: begin o_cmd.op = OP_SPD; n_state = ST_MD;  end
            ST_MD:  begin o_cmd.op = OP_MD;  n_state = ST_D;   end
            ST_D:   begin o_cmd.op = OP_D;   n_state = ST_ANG; end
            ST_ANG: begin o_cmd.op = OP_ANG; n_state = ST_R;   end
            ST_R:   begin o_cmd.op = OP_R;   n_state = ST_CW1; end
            ST_CW1: begin
                if (i_stat.cordic_idle) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin o_cmd.op = OP_DIV; n_state = ST_DW;  end
            ST_DW: begin
                if (i_stat.div_idle) begin
                    n_state = ST_T;
                end
            end
            ST_T:   begin o_cmd.op = OP_T;   n_state = ST_MW;  end
            ST_MW:  begin o_cmd.op = OP_MW;  n_state = ST_W;   end
            ST_W:   begin o_cmd.op = OP_W;   n_state = ST_MLL; end
            ST_MLL: begin o_cmd.op = OP_MLL; n_state = ST_HLL; end
            ST_HLL: begin o_cmd.op = OP_HLL; n_state = ST_HHL; end
            ST_HHL: begin o_cmd.op = OP_HHL; n_state = ST_HLH; end
            ST_HLH: begin o_cmd.op = OP_HLH; n_state = ST_HC;  end
            ST_HC:  begin o_cmd.op = OP_HC;  n_state = ST_CW2; end
            ST_CW2: begin
                if (i_stat.cordic_idle) begin
                    n_state = ST_MX;
                end
            end
            ST_MX:  begin o_cmd.op = OP_MX;  n_state = ST_X;   end
            ST_X:   begin o_cmd.op = OP_X;   n_state = ST_Y;   end
            ST_Y:   begin o_cmd.op = OP_Y;   n_state = ST_FIN; end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

### hdl/kinematic_bicycle_step_unit.sv
`default_nettype none
`include "assert_macros.svh"

// One forward-Euler step of the kinematic bicycle model per item: the speed takes
// accel*dt, the heading takes v*(1/L)*tan(steer)*dt, then x and y take v*cos and
// v*sin of the new heading times dt. Each item returns heading (binary angle that
// wraps), speed (Q16.16) and x, y (Q32.16), all saturating but the heading. One
// item is in work at a time: a new item is taken only once the previous one has
// reached the output register, and a step waits at its end while that register
// still holds an undrained result. The two CORDIC passes and the bit-serial
// divider for tan are the long parts of a step; a further item is taken while
// the last result waits in the output register. The time step and inverse
// wheelbase sit on an APB port: time_step at byte address 0, inverse_wheelbase
// at address 4, and they are meant to be written only while the block is idle.

module kinematic_bicycle_step_unit import kbs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [TS_W-1:0]  r_time_step;
    logic [IWB_W-1:0] r_inv_wb;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    // Register writes land on the access phase; writes use the low bits of pwdata.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_inv_wb    <= INV_WB_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_TIME_STEP: r_time_step <= pwdata[TS_W-1:0];
                REG_INV_WB:    r_inv_wb    <= pwdata[IWB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIME_STEP: prdata = {16'd0, r_time_step};
            REG_INV_WB:    prdata = {8'd0, r_inv_wb};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // The controller sequences the step; the datapath holds the vehicle state,
    // the shared multiplier, the CORDIC and the divider.
    kbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kbs_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_time_step (r_time_step),
        .i_inv_wb    (r_inv_wb),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Once an item is taken the block is busy for the whole step.
    `KBS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "Ready right after an accepted item")

endmodule

`default_nettype wire
